FILE: src/nsv_pkg.sv
// ----------------------------------------------------------------------------
// nsv_pkg
// Shared types and constants of the numeric string validator: character
// codes, previous-character classes and the class flags of one character.
// ----------------------------------------------------------------------------
package nsv_pkg;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EXP_U = 8'h45;
	localparam logic [7:0] CH_EXP_L = 8'h65;

	// class of the previous character
	localparam logic [1:0] CLS_START  = 2'd0;
	localparam logic [1:0] CLS_DIGIT  = 2'd1;
	localparam logic [1:0] CLS_EXP    = 2'd2;
	localparam logic [1:0] CLS_SGNDOT = 2'd3;

	// counter limits
	localparam logic [1:0] CNT_MAX      = 2'd3;
	localparam logic [1:0] EXP_LIMIT    = 2'd1;
	localparam logic [1:0] DOT_LIMIT    = 2'd1;
	localparam logic [1:0] SIGN_LIMIT   = 2'd2;

	// class flags of one character
	typedef struct packed {
		logic is_digit;
		logic is_exp;
		logic is_sign;
		logic is_dot;
	} char_class_t;

endpackage

FILE: src/numeric_string_validator.sv
// ----------------------------------------------------------------------------
// numeric_string_validator
// Checks a string, streamed one character per item, against loose number
// rules and returns one verdict per string.
//
// Input channel: in_valid / in_ready with character and last_char. Each
// accepted item is one byte of the string; last_char marks the final one.
// Output channel: out_valid / out_ready with is_number, one item per
// string, sent after its final character.
// An accepted item lands in an input register; when it moves on, its rules
// are applied and, for a final character, the verdict is loaded into the
// output register, where it is visible until out_ready takes it. One item
// is accepted every cycle unless a final character waits on a full output
// register.
// While the receiver stalls with a verdict held, non-final characters keep
// flowing; a final character waits in the input register until the output
// register frees, and in_ready drops behind it.
// Reset clears the rule state and both valid flags; the block is ready
// straight out of reset.
// ----------------------------------------------------------------------------
module numeric_string_validator
	import nsv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] character,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       is_number
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        out_valid_q;
	logic        is_number_q;
	logic        adv_s1;
	logic        verdict;
	char_class_t cls;

	// stage one moves on unless a final character finds the output full and stalled
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= character;
			last_s1 <= last_char;
		end
	end

	nsv_classify u_classify (
		.character (char_s1),
		.cls       (cls)
	);

	nsv_rules u_rules (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv_s1),
		.cls     (cls),
		.last    (last_s1),
		.verdict (verdict)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			is_number_q <= verdict;
		end
	end

	assign out_valid = out_valid_q;
	assign is_number = is_number_q;

	// a final character always yields a verdict on the next cycle
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> out_valid_q)
		else $error("final character did not produce a result");

	// a held stage-one item keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled stage-one item changed");

	// a stalled final character only waits on a full, stalled output
	a_s1_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> last_s1 && out_valid_q && !out_ready)
		else $error("stage one stalled without cause");

endmodule

FILE: src/nsv_classify.sv
// ----------------------------------------------------------------------------
// nsv_classify
// Decodes one character byte into its class flags.
// ----------------------------------------------------------------------------
module nsv_classify
	import nsv_pkg::*;
(
	input  logic [7:0]  character,
	output char_class_t cls
);

	// range and equality compares on the byte
	always_comb begin
		cls.is_digit = (character >= CH_ZERO) && (character <= CH_NINE);
		cls.is_exp   = (character == CH_EXP_U) || (character == CH_EXP_L);
		cls.is_sign  = (character == CH_PLUS) || (character == CH_MINUS);
		cls.is_dot   = (character == CH_DOT);
	end

endmodule

FILE: src/nsv_rules.sv
// ----------------------------------------------------------------------------
// nsv_rules
// Per-string rule state: previous class, failure flag and saturating
// counters. Applies the rules for each stepped item and forms the verdict
// on the final character, then clears the state for the next string.
// ----------------------------------------------------------------------------
module nsv_rules
	import nsv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  char_class_t cls,
	input  logic        last,
	output logic        verdict
);

	logic [1:0] prev_class_q;
	logic       failed_q;
	logic [1:0] exp_cnt_q;
	logic [1:0] dot_cnt_q;
	logic [1:0] sign_cnt_q;

	logic       bad;
	logic       failed_d;
	logic [1:0] exp_cnt_d;
	logic [1:0] dot_cnt_d;
	logic [1:0] sign_cnt_d;
	logic [1:0] prev_class_d;

	// rule checks on the byte, against the previous class and for a final character
	always_comb begin
		bad = !(cls.is_digit || cls.is_exp || cls.is_sign || cls.is_dot);
		if ((prev_class_q == CLS_EXP) && !cls.is_digit && !cls.is_sign) begin
			bad = 1'b1;
		end
		if ((prev_class_q == CLS_SGNDOT) && !cls.is_digit) begin
			bad = 1'b1;
		end
		if (cls.is_exp && (prev_class_q != CLS_DIGIT)) begin
			bad = 1'b1;
		end
		if (last && (cls.is_exp || cls.is_sign || cls.is_dot)) begin
			bad = 1'b1;
		end
	end

	// next counters, saturating
	always_comb begin
		exp_cnt_d  = (cls.is_exp && exp_cnt_q != CNT_MAX) ? exp_cnt_q + 2'd1 : exp_cnt_q;
		dot_cnt_d  = (cls.is_dot && dot_cnt_q != CNT_MAX) ? dot_cnt_q + 2'd1 : dot_cnt_q;
		sign_cnt_d = (cls.is_sign && sign_cnt_q != CNT_MAX) ? sign_cnt_q + 2'd1
			: sign_cnt_q;
		failed_d   = failed_q || bad;
	end

	// class of this character for the next step
	always_comb begin
		priority if (cls.is_digit) begin
			prev_class_d = CLS_DIGIT;
		end else if (cls.is_exp) begin
			prev_class_d = CLS_EXP;
		end else if (cls.is_sign || cls.is_dot) begin
			prev_class_d = CLS_SGNDOT;
		end else begin
			prev_class_d = CLS_START;
		end
	end

	// verdict on the final character
	assign verdict = !failed_d && (exp_cnt_d <= EXP_LIMIT) && (dot_cnt_d <= DOT_LIMIT)
		&& (sign_cnt_d <= SIGN_LIMIT);

	// state registers, cleared after the final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_class_q <= CLS_START;
			failed_q     <= 1'b0;
			exp_cnt_q    <= 2'd0;
			dot_cnt_q    <= 2'd0;
			sign_cnt_q   <= 2'd0;
		end else if (step) begin
			if (last) begin
				prev_class_q <= CLS_START;
				failed_q     <= 1'b0;
				exp_cnt_q    <= 2'd0;
				dot_cnt_q    <= 2'd0;
				sign_cnt_q   <= 2'd0;
			end else begin
				prev_class_q <= prev_class_d;
				failed_q     <= failed_d;
				exp_cnt_q    <= exp_cnt_d;
				dot_cnt_q    <= dot_cnt_d;
				sign_cnt_q   <= sign_cnt_d;
			end
		end
	end

	// state is clean after a string ends
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && last |=> (prev_class_q == CLS_START) && !failed_q
		&& (exp_cnt_q == 2'd0) && (dot_cnt_q == 2'd0) && (sign_cnt_q == 2'd0))
		else $error("rule state not cleared after final character");

	// a passing string always ends on a digit
	a_pass_ends_digit: assert property (@(posedge clk) disable iff (!arst_n)
		step && last && verdict |-> cls.is_digit)
		else $error("passing verdict on a non-digit final character");

endmodule
